// ===== rtl/core/rsmt_pkg.sv =====
// Shared types and constants for the RS-485 multidrop master transaction block.
// Holds the item structs, protocol bytes and controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps

package rsmt_pkg;

	// Protocol bytes
	localparam logic [7:0] ACK_BYTE  = 8'hcc;
	localparam logic [7:0] CMD_WRITE = 8'h01;
	localparam logic [7:0] CMD_READ  = 8'h02;

	// Default lengths and their legal maxima
	localparam int TX_LEN_DEF = 10;
	localparam int RX_LEN_DEF = 3;
	localparam int TX_LEN_MAX = 10;
	localparam int RX_LEN_MAX = 3;

	// Configuration register indexes and reset values
	localparam logic CFG_TX_PAYLOAD_LO = 1'b0;
	localparam logic CFG_TX_PAYLOAD_HI = 1'b1;
	localparam logic [63:0] TX_PAYLOAD_LO_RST = 64'd506097522914230528;
	localparam logic [15:0] TX_PAYLOAD_HI_RST = 16'd2312;

	// Input request kinds
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_RX    = 1'b1;

	// Result kinds
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] slave_address;
		logic [7:0] command_code;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  tx_byte;
		logic        tx_ninth_bit;
		logic        turn_to_receive;
		logic        status_ok;
		logic [23:0] read_data;
		logic        last_of_run;
	} out_item_t;

	// Source of the result loaded into the output register
	typedef enum logic [2:0] {
		SEL_ADDR,
		SEL_CMD,
		SEL_PAYLOAD,
		SEL_SUM,
		SEL_FINISH
	} out_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     load_start;
		logic     clear_sum;
		logic     add_rx;
		logic     add_tx;
		logic     set_status;
		logic     status_val;
		logic     out_load;
		out_sel_t out_sel;
		logic     out_last;
		logic     use_read_data;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic addr_match;
		logic cmd_match;
		logic cmd_is_write;
		logic cmd_is_read;
		logic ack_match;
		logic sum_match;
		logic tx_done;
		logic rx_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/core/rsmt_dp.sv =====
// Datapath of the RS-485 master transaction: payload registers, running sum,
// byte counter, read buffer, sticky status and the output register.
// Depends on rsmt_pkg.
`timescale 1ns / 1ps

module rsmt_dp #(
	parameter int TX_LEN = rsmt_pkg::TX_LEN_DEF,
	parameter int RX_LEN = rsmt_pkg::RX_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [63:0]          cfg_data,
	input  rsmt_pkg::in_item_t   in_data,
	input  rsmt_pkg::dp_cmd_t    cmd,
	output rsmt_pkg::dp_status_t status,
	input  logic                 out_stall,
	output logic                 out_valid,
	output rsmt_pkg::out_item_t  out_data
);

	logic [63:0] payload_lo_q;
	logic [15:0] payload_hi_q;
	logic [7:0]  addr_q;
	logic [7:0]  command_q;
	logic [7:0]  sum_q;
	logic [3:0]  idx_q;
	logic [7:0]  rbuf_q [3];
	logic        status_q;
	logic        out_valid_q;
	rsmt_pkg::out_item_t out_q;

	logic [7:0]  pay_bytes [rsmt_pkg::TX_LEN_MAX];
	logic [7:0]  pay_byte;
	logic        status_next;
	logic [23:0] rdata;
	rsmt_pkg::out_item_t out_next;

	// Split the payload registers into bytes
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			pay_bytes[k] = payload_lo_q[8*k +: 8];
		end
		pay_bytes[8] = payload_hi_q[7:0];
		pay_bytes[9] = payload_hi_q[15:8];
	end

	assign pay_byte = (idx_q < 4'(rsmt_pkg::TX_LEN_MAX)) ? pay_bytes[idx_q] : 8'h00;

	// Gather read bytes, positions beyond the read length stay zero
	always_comb begin
		for (int k = 0; k < rsmt_pkg::RX_LEN_MAX; k++) begin
			rdata[8*k +: 8] = (k < RX_LEN) ? rbuf_q[k] : 8'h00;
		end
	end

	assign status_next = cmd.set_status ? cmd.status_val : status_q;

	// Status flags for the controller
	always_comb begin
		status.addr_match   = (in_data.rx_byte == addr_q);
		status.cmd_match    = (in_data.rx_byte == command_q);
		status.cmd_is_write = (command_q == rsmt_pkg::CMD_WRITE);
		status.cmd_is_read  = (command_q == rsmt_pkg::CMD_READ);
		status.ack_match    = (in_data.rx_byte == rsmt_pkg::ACK_BYTE);
		status.sum_match    = (in_data.rx_byte == sum_q);
		status.tx_done      = (idx_q == 4'(TX_LEN));
		status.rx_last      = (idx_q == 4'(RX_LEN - 1));
		status.out_free     = !out_valid_q || !out_stall;
	end

	// Build the next result
	always_comb begin
		out_next = '0;
		out_next.last_of_run = cmd.out_last;
		case (cmd.out_sel)
			rsmt_pkg::SEL_ADDR: begin
				out_next.result_kind     = rsmt_pkg::KIND_BYTE;
				out_next.tx_byte         = in_data.slave_address;
				out_next.tx_ninth_bit    = 1'b1;
				out_next.turn_to_receive = 1'b1;
			end
			rsmt_pkg::SEL_CMD: begin
				out_next.result_kind     = rsmt_pkg::KIND_BYTE;
				out_next.tx_byte         = command_q;
				out_next.turn_to_receive = 1'b1;
			end
			rsmt_pkg::SEL_PAYLOAD: begin
				out_next.result_kind = rsmt_pkg::KIND_BYTE;
				out_next.tx_byte     = pay_byte;
			end
			rsmt_pkg::SEL_SUM: begin
				out_next.result_kind     = rsmt_pkg::KIND_BYTE;
				out_next.tx_byte         = sum_q;
				out_next.turn_to_receive = 1'b1;
			end
			rsmt_pkg::SEL_FINISH: begin
				out_next.result_kind = rsmt_pkg::KIND_FINISH;
				out_next.status_ok   = status_next;
				out_next.read_data   = cmd.use_read_data ? rdata : 24'h000000;
			end
			default: begin
				out_next = '0;
			end
		endcase
	end

	// Control registers: configuration, counters, status, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_lo_q <= rsmt_pkg::TX_PAYLOAD_LO_RST;
			payload_hi_q <= rsmt_pkg::TX_PAYLOAD_HI_RST;
			addr_q       <= '0;
			command_q    <= '0;
			sum_q        <= '0;
			idx_q        <= '0;
			status_q     <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			// Take configuration writes
			if (cfg_we) begin
				case (cfg_index)
					rsmt_pkg::CFG_TX_PAYLOAD_LO: payload_lo_q <= cfg_data;
					rsmt_pkg::CFG_TX_PAYLOAD_HI: payload_hi_q <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			// Capture the transaction target
			if (cmd.load_start) begin
				addr_q    <= in_data.slave_address;
				command_q <= in_data.command_code;
			end
			// Advance sum and byte counter
			if (cmd.clear_sum) begin
				sum_q <= '0;
				idx_q <= '0;
			end else if (cmd.add_rx) begin
				sum_q <= sum_q + in_data.rx_byte;
				idx_q <= idx_q + 4'd1;
			end else if (cmd.add_tx) begin
				sum_q <= sum_q + pay_byte;
				idx_q <= idx_q + 4'd1;
			end
			status_q <= status_next;
			// Hold or drain the output register
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: read buffer and output item
	always_ff @(posedge clk) begin
		if (cmd.add_rx) begin
			rbuf_q[idx_q[1:0]] <= in_data.rx_byte;
		end
		if (cmd.out_load) begin
			out_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/rsmt_ctrl.sv =====
// Controller of the RS-485 master transaction: protocol phase machine that
// drives the datapath commands and the input stall. Depends on rsmt_pkg.
`timescale 1ns / 1ps

module rsmt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 req_type,
	output logic                 in_stall,
	input  rsmt_pkg::dp_status_t status,
	output rsmt_pkg::dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR_ECHO,
		ST_CMD_ECHO,
		ST_SEND,
		ST_ACK,
		ST_READ_DATA,
		ST_READ_SUM
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   accept;
	logic   rx_item;

	assign in_stall = (state_q == ST_SEND) || !status.out_free;
	assign accept   = in_valid && !in_stall;
	assign rx_item  = accept && (req_type == rsmt_pkg::REQ_RX);

	// Decode the phase and the accepted item into datapath commands
	always_comb begin
		cmd        = '0;
		cmd.out_sel = rsmt_pkg::SEL_FINISH;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_type == rsmt_pkg::REQ_START)) begin
					cmd.load_start = 1'b1;
					cmd.out_load   = 1'b1;
					cmd.out_sel    = rsmt_pkg::SEL_ADDR;
					cmd.out_last   = 1'b1;
					state_next     = ST_ADDR_ECHO;
				end
			end
			ST_ADDR_ECHO: begin
				if (rx_item) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					if (!status.addr_match) begin
						cmd.set_status = 1'b1;
						cmd.status_val = 1'b0;
						state_next     = ST_IDLE;
					end else if (status.cmd_is_write || status.cmd_is_read) begin
						cmd.out_sel = rsmt_pkg::SEL_CMD;
						state_next  = ST_CMD_ECHO;
					end else begin
						state_next = ST_IDLE;
					end
				end
			end
			ST_CMD_ECHO: begin
				if (rx_item) begin
					if (!status.cmd_match) begin
						cmd.set_status = 1'b1;
						cmd.status_val = 1'b0;
						cmd.out_load   = 1'b1;
						cmd.out_last   = 1'b1;
						state_next     = ST_IDLE;
					end else begin
						cmd.clear_sum = 1'b1;
						state_next    = status.cmd_is_write ? ST_SEND : ST_READ_DATA;
					end
				end
			end
			ST_SEND: begin
				// Emit one payload byte per free output slot, checksum last
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					if (status.tx_done) begin
						cmd.out_sel  = rsmt_pkg::SEL_SUM;
						cmd.out_last = 1'b1;
						state_next   = ST_ACK;
					end else begin
						cmd.out_sel = rsmt_pkg::SEL_PAYLOAD;
						cmd.add_tx  = 1'b1;
					end
				end
			end
			ST_ACK: begin
				if (rx_item) begin
					cmd.set_status = 1'b1;
					cmd.status_val = status.ack_match;
					cmd.out_load   = 1'b1;
					cmd.out_last   = 1'b1;
					state_next     = ST_IDLE;
				end
			end
			ST_READ_DATA: begin
				if (rx_item) begin
					cmd.add_rx = 1'b1;
					if (status.rx_last) begin
						state_next = ST_READ_SUM;
					end
				end
			end
			ST_READ_SUM: begin
				if (rx_item) begin
					cmd.set_status    = 1'b1;
					cmd.status_val    = status.sum_match;
					cmd.out_load      = 1'b1;
					cmd.out_last      = 1'b1;
					cmd.use_read_data = 1'b1;
					state_next        = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Hold the phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ===== rtl/core/rs485_master_transaction_top.sv =====
// Timing: a result is offered the cycle after its item is accepted; a write command echo
// leads to the send phase, which loads the TX_LEN payload bytes, then the checksum, into
// the output register. Throughput: one item per cycle while input is not stalled; payload
// and checksum bytes leave one per cycle unless the output is stalled, and input stalls
// until the checksum is loaded. A full output register that is stalled holds off new items.
// Reset: phase idle, counters, sum zero, status good, payload at defaults. Uses rsmt_pkg.
`timescale 1ns / 1ps

module rs485_master_transaction_top #(
	parameter int TX_LEN = rsmt_pkg::TX_LEN_DEF,
	parameter int RX_LEN = rsmt_pkg::RX_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  rsmt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rsmt_pkg::out_item_t out_data
);

	rsmt_pkg::dp_cmd_t    cmd;
	rsmt_pkg::dp_status_t status;

	// Phase controller
	rsmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (in_data.req_type),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath and output register
	rsmt_dp #(
		.TX_LEN (TX_LEN),
		.RX_LEN (RX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ===== tb/sv/rs485_master_transaction_top_tb.sv =====
// Self-checking bench for the RS-485 multidrop master transaction block: a directed
// table, then phase-aware random bus events, each checked against a built-in predictor.
// Depends on rsmt_pkg and rs485_master_transaction_top.
`timescale 1ns / 1ps

module rs485_master_transaction_top_tb;

	localparam int STALL_PCT   = 30;
	localparam int SETTLE_CYC  = 20;
	localparam int STUCK_LIMIT = 3000;
	localparam int PHASE_ITEMS = 84;

	typedef enum logic [2:0] {
		LINK_IDLE,
		LINK_ADDR_ECHO,
		LINK_CMD_ECHO,
		LINK_ACK,
		LINK_READ_DATA,
		LINK_READ_SUM
	} link_phase_t;

	typedef struct {
		rsmt_pkg::in_item_t  item;
		bit                  typed;
		rsmt_pkg::out_item_t want;
	} dir_row_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic                cfg_index = rsmt_pkg::CFG_TX_PAYLOAD_LO;
	logic [63:0]         cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	rsmt_pkg::in_item_t  in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	rsmt_pkg::out_item_t out_data;

	// Predictor state and configuration shadow
	link_phase_t link_phase  = LINK_IDLE;
	logic [7:0]  call_addr   = '0;
	logic [7:0]  call_cmd    = '0;
	logic [7:0]  check_sum   = '0;
	logic [1:0]  rd_count    = 2'd0;
	logic [7:0]  rd_bytes [3] = '{default: 8'h00};
	logic        good_status = 1'b1;
	logic [63:0] pay_lo      = rsmt_pkg::TX_PAYLOAD_LO_RST;
	logic [15:0] pay_hi      = rsmt_pkg::TX_PAYLOAD_HI_RST;
	bit          event_ignored;

	rsmt_pkg::out_item_t step_results [$];
	rsmt_pkg::out_item_t expected_results [$];
	dir_row_t            dir_rows [$];
	rsmt_pkg::out_item_t got_res;
	rsmt_pkg::out_item_t want_res;
	int          mismatch_count = 0;
	int          stuck_cycles   = 0;
	bit          in_idle_on     = 1'b1;
	bit          out_idle_on    = 1'b1;

	rs485_master_transaction_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
		end
	endtask

	function automatic rsmt_pkg::out_item_t mk_tx(input logic [7:0] b, input bit ninth,
			input bit release_line, input bit last);
		rsmt_pkg::out_item_t r;
		r = '0;
		r.result_kind     = rsmt_pkg::KIND_BYTE;
		r.tx_byte         = b;
		r.tx_ninth_bit    = ninth;
		r.turn_to_receive = release_line;
		r.last_of_run     = last;
		return r;
	endfunction

	function automatic rsmt_pkg::out_item_t mk_fin(input bit ok, input logic [23:0] data,
			input bit last);
		rsmt_pkg::out_item_t r;
		r = '0;
		r.result_kind = rsmt_pkg::KIND_FINISH;
		r.status_ok   = ok;
		r.read_data   = data;
		r.last_of_run = last;
		return r;
	endfunction

	function automatic rsmt_pkg::in_item_t start_req(input logic [7:0] addr,
			input logic [7:0] cmd);
		rsmt_pkg::in_item_t it;
		it.req_type      = rsmt_pkg::REQ_START;
		it.slave_address = addr;
		it.command_code  = cmd;
		it.rx_byte       = 8'($urandom_range(255));
		return it;
	endfunction

	function automatic rsmt_pkg::in_item_t rx_req(input logic [7:0] b);
		rsmt_pkg::in_item_t it;
		it.req_type      = rsmt_pkg::REQ_RX;
		it.slave_address = 8'($urandom_range(255));
		it.command_code  = 8'($urandom_range(255));
		it.rx_byte       = b;
		return it;
	endfunction

	function automatic logic [7:0] payload_byte(input int k);
		if (k < 8) return pay_lo[8*k +: 8];
		return pay_hi[8*(k-8) +: 8];
	endfunction

	// End the call: report the sticky status and return to idle
	task automatic close_call(input logic [23:0] data);
		step_results.push_back(mk_fin(good_status, data, 1'b0));
		link_phase = LINK_IDLE;
	endtask

	// Work out the results of one bus event and advance the predicted state
	task automatic predict_bus_event(input rsmt_pkg::in_item_t it);
		logic [7:0] b;
		step_results.delete();
		event_ignored = 1'b0;
		if (it.req_type == rsmt_pkg::REQ_START) begin
			if (link_phase != LINK_IDLE) begin
				event_ignored = 1'b1;
			end else begin
				call_addr = it.slave_address;
				call_cmd  = it.command_code;
				step_results.push_back(mk_tx(it.slave_address, 1'b1, 1'b1, 1'b0));
				link_phase = LINK_ADDR_ECHO;
			end
		end else begin
			case (link_phase)
				LINK_ADDR_ECHO: begin
					if (it.rx_byte != call_addr) begin
						good_status = 1'b0;
						close_call('0);
					end else if (call_cmd == rsmt_pkg::CMD_WRITE ||
							call_cmd == rsmt_pkg::CMD_READ) begin
						step_results.push_back(mk_tx(call_cmd, 1'b0, 1'b1, 1'b0));
						link_phase = LINK_CMD_ECHO;
					end else begin
						close_call('0);
					end
				end
				LINK_CMD_ECHO: begin
					if (it.rx_byte != call_cmd) begin
						good_status = 1'b0;
						close_call('0);
					end else if (call_cmd == rsmt_pkg::CMD_WRITE) begin
						check_sum = '0;
						for (int k = 0; k < rsmt_pkg::TX_LEN_DEF; k++) begin
							b = payload_byte(k);
							check_sum += b;
							step_results.push_back(mk_tx(b, 1'b0, 1'b0, 1'b0));
						end
						step_results.push_back(mk_tx(check_sum, 1'b0, 1'b1, 1'b0));
						link_phase = LINK_ACK;
					end else begin
						check_sum  = '0;
						rd_count   = 2'd0;
						link_phase = LINK_READ_DATA;
					end
				end
				LINK_ACK: begin
					good_status = (it.rx_byte == rsmt_pkg::ACK_BYTE);
					close_call('0);
				end
				LINK_READ_DATA: begin
					rd_bytes[rd_count] = it.rx_byte;
					check_sum += it.rx_byte;
					rd_count++;
					if (rd_count >= 2'(rsmt_pkg::RX_LEN_DEF)) link_phase = LINK_READ_SUM;
				end
				LINK_READ_SUM: begin
					good_status = (it.rx_byte == check_sum);
					close_call({rd_bytes[2], rd_bytes[1], rd_bytes[0]});
				end
				default: begin
					event_ignored = 1'b1;
				end
			endcase
		end
		if (step_results.size() > 0) begin
			step_results[step_results.size()-1].last_of_run = 1'b1;
		end
	endtask

	// Offer one item, hold it until accepted, then queue what it should cause
	task automatic send_item(input rsmt_pkg::in_item_t it, input bit typed,
			input rsmt_pkg::out_item_t want);
		while (in_idle_on && $urandom_range(99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_bus_event(it);
		if (typed) begin
			expected_results.push_back(want);
		end else begin
			foreach (step_results[i]) expected_results.push_back(step_results[i]);
		end
	endtask

	// Drop valid and wait until every expected result has come, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic load_payload(input logic [63:0] lo, input logic [15:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= rsmt_pkg::CFG_TX_PAYLOAD_LO;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= rsmt_pkg::CFG_TX_PAYLOAD_HI;
		cfg_data  <= {32'($urandom), 16'($urandom), hi};
		@(posedge clk);
		cfg_we <= 1'b0;
		pay_lo = lo;
		pay_hi = hi;
	endtask

	// Mostly the expected byte; otherwise a random byte or a start that gets ignored
	function automatic rsmt_pkg::in_item_t reply_or_noise(input logic [7:0] want,
			input int pct);
		int r;
		r = $urandom_range(99);
		if (r < pct) return rx_req(want);
		if (r < 97) return rx_req(8'($urandom_range(255)));
		return start_req(8'($urandom_range(255)), 8'($urandom_range(255)));
	endfunction

	// Random bus events shaped by the predicted phase
	task automatic run_random(input int n_items);
		int                 done;
		int                 r;
		logic [7:0]         c;
		rsmt_pkg::in_item_t it;
		done = 0;
		while (done < n_items) begin
			case (link_phase)
				LINK_ADDR_ECHO: it = reply_or_noise(call_addr, 90);
				LINK_CMD_ECHO:  it = reply_or_noise(call_cmd, 90);
				LINK_ACK:       it = reply_or_noise(rsmt_pkg::ACK_BYTE, 85);
				LINK_READ_DATA: it = reply_or_noise(8'h00, 0);
				LINK_READ_SUM:  it = reply_or_noise(check_sum, 85);
				default: begin
					r = $urandom_range(99);
					if (r < 10) begin
						it = rx_req(8'($urandom_range(255)));
					end else begin
						if (r < 48) c = rsmt_pkg::CMD_WRITE;
						else if (r < 85) c = rsmt_pkg::CMD_READ;
						else c = 8'($urandom_range(255));
						it = start_req(8'($urandom_range(255)), c);
					end
				end
			endcase
			send_item(it, 1'b0, '0);
			if (!event_ignored) done++;
		end
	endtask

	// Check each accepted result against the oldest expectation; stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: %h", out_data));
			end else begin
				got_res  = out_data;
				want_res = expected_results.pop_front();
				check_field("result_kind", 64'(got_res.result_kind),
					64'(want_res.result_kind));
				check_field("tx_byte", 64'(got_res.tx_byte), 64'(want_res.tx_byte));
				check_field("tx_ninth_bit", 64'(got_res.tx_ninth_bit),
					64'(want_res.tx_ninth_bit));
				check_field("turn_to_receive", 64'(got_res.turn_to_receive),
					64'(want_res.turn_to_receive));
				check_field("status_ok", 64'(got_res.status_ok), 64'(want_res.status_ok));
				check_field("read_data", 64'(got_res.read_data), 64'(want_res.read_data));
				check_field("last_of_run", 64'(got_res.last_of_run),
					64'(want_res.last_of_run));
			end
		end
		out_stall <= out_idle_on && ($urandom_range(99) < STALL_PCT);
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Watchdog expired after %0d idle cycles", STUCK_LIMIT);
				$display("Some tests failed");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	initial begin
		// Directed table: extremes, both commands and the odd paths marked on the rows
		dir_rows.push_back('{rx_req(8'h5a), 1'b0, '0});                      // byte while idle
		dir_rows.push_back('{start_req(8'hff, rsmt_pkg::CMD_WRITE), 1'b1,
			mk_tx(8'hff, 1'b1, 1'b1, 1'b1)});
		dir_rows.push_back('{start_req(8'h12, rsmt_pkg::CMD_READ), 1'b0, '0}); // start while busy
		dir_rows.push_back('{rx_req(8'hff), 1'b1, mk_tx(rsmt_pkg::CMD_WRITE, 1'b0, 1'b1, 1'b1)});
		dir_rows.push_back('{rx_req(rsmt_pkg::CMD_WRITE), 1'b0, '0});        // payload burst
		dir_rows.push_back('{rx_req(rsmt_pkg::ACK_BYTE), 1'b1, mk_fin(1'b1, '0, 1'b1)});
		dir_rows.push_back('{start_req(8'h00, rsmt_pkg::CMD_READ), 1'b1,
			mk_tx(8'h00, 1'b1, 1'b1, 1'b1)});
		dir_rows.push_back('{rx_req(8'h00), 1'b1, mk_tx(rsmt_pkg::CMD_READ, 1'b0, 1'b1, 1'b1)});
		dir_rows.push_back('{rx_req(rsmt_pkg::CMD_READ), 1'b0, '0});
		dir_rows.push_back('{rx_req(8'hff), 1'b0, '0});
		dir_rows.push_back('{rx_req(8'h00), 1'b0, '0});
		dir_rows.push_back('{rx_req(8'h80), 1'b0, '0});
		dir_rows.push_back('{rx_req(8'h7f), 1'b0, '0});                      // good read sum
		dir_rows.push_back('{start_req(8'h5a, 8'hff), 1'b1, mk_tx(8'h5a, 1'b1, 1'b1, 1'b1)});
		dir_rows.push_back('{rx_req(8'h5b), 1'b1, mk_fin(1'b0, '0, 1'b1)});  // address mismatch
		dir_rows.push_back('{start_req(8'ha5, 8'hff), 1'b1, mk_tx(8'ha5, 1'b1, 1'b1, 1'b1)});
		dir_rows.push_back('{rx_req(8'ha5), 1'b0, '0});                      // other command
		dir_rows.push_back('{start_req(8'h33, rsmt_pkg::CMD_WRITE), 1'b1,
			mk_tx(8'h33, 1'b1, 1'b1, 1'b1)});
		dir_rows.push_back('{rx_req(8'h33), 1'b1, mk_tx(rsmt_pkg::CMD_WRITE, 1'b0, 1'b1, 1'b1)});
		dir_rows.push_back('{rx_req(rsmt_pkg::CMD_READ), 1'b1,
			mk_fin(1'b0, '0, 1'b1)});                                    // command mismatch
		dir_rows.push_back('{start_req(8'h10, rsmt_pkg::CMD_WRITE), 1'b1,
			mk_tx(8'h10, 1'b1, 1'b1, 1'b1)});
		dir_rows.push_back('{rx_req(8'h10), 1'b1, mk_tx(rsmt_pkg::CMD_WRITE, 1'b0, 1'b1, 1'b1)});
		dir_rows.push_back('{rx_req(rsmt_pkg::CMD_WRITE), 1'b0, '0});
		dir_rows.push_back('{rx_req(8'h00), 1'b1, mk_fin(1'b0, '0, 1'b1)});  // wrong ack

		// Hold reset, then release it on a clock edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

		// Random phases, each under its own payload setting
		for (int p = 0; p < 4; p++) begin
			drain_results();
			case (p)
				0: load_payload({$urandom, $urandom}, 16'($urandom));
				1: load_payload('1, '1);
				2: load_payload('0, '0);
				default: load_payload({$urandom, $urandom}, 16'($urandom));
			endcase
			in_idle_on  = (p != 1);
			out_idle_on = (p != 1);
			run_random(PHASE_ITEMS);
		end

		drain_results();
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
